>>> rtl/core/fbc_pkg.sv
// Shared types, widths and codes for the frustum box cull core.
`timescale 1ns / 1ps

package fbc_pkg;

    localparam int VALUE_WIDTH = 32;                   // stored matrix element width
    localparam int CW = VALUE_WIDTH + 1;               // plane coefficient width
    localparam int TW = 33;                            // center +/- half extent
    localparam int PW = CW + TW;                       // product width
    localparam int SW = PW + 2;                        // sum of four terms
    localparam int FRAC_BITS = 16;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int NUM_PLANES = 6;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TEST  = 1'b1;

    localparam logic [1:0] ROW_W = 2'd3;               // fourth matrix row

    typedef logic signed [VALUE_WIDTH-1:0] t_elem;
    typedef logic signed [CW-1:0] t_coef;

    // one input word as seen on the request channel
    typedef struct packed {
        logic               req_type;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        half_x;
        logic [30:0]        half_y;
        logic [30:0]        half_z;
    } t_req;

    typedef struct packed {
        logic visible;
    } t_rsp;

    // word passed from cell to cell
    typedef struct packed {
        logic valid;
        t_req req;
        logic vis;
    } t_word;

    // wrap the written value to the stored element width
    function automatic t_elem to_elem(logic signed [31:0] v);
        return VALUE_WIDTH'(v);
    endfunction

endpackage

>>> rtl/core/fbc_if.sv
// Request and response channel interfaces for the frustum box cull core.
`timescale 1ns / 1ps

interface fbc_req_if;
    logic          valid;
    logic          ready;
    fbc_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fbc_rsp_if;
    logic          valid;
    logic          ready;
    fbc_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/fbc_cell.sv
// One plane cell: holds its plane coefficients and tests the passing box against them.
`timescale 1ns / 1ps

module fbc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_row,
    input  logic           i_neg,
    input  fbc_pkg::t_word i_word,
    output fbc_pkg::t_word o_word
);

    fbc_pkg::t_elem r_r4 [4];
    fbc_pkg::t_elem r_rr [4];
    fbc_pkg::t_coef r_coef [4];

    fbc_pkg::t_word r_s1_word;
    logic signed [fbc_pkg::PW-1:0] r_p [3];
    fbc_pkg::t_coef r_d;
    fbc_pkg::t_word r_out;

    logic                           is_wr;
    logic [1:0]                     wr_col;
    logic [1:0]                     wr_row;
    fbc_pkg::t_elem                 wr_val;
    logic signed [fbc_pkg::TW-1:0]  n_t [3];
    logic signed [fbc_pkg::PW-1:0]  n_p [3];
    logic signed [fbc_pkg::SW-1:0]  sum;
    logic signed [31:0]             ctr [3];
    logic [30:0]                    half [3];

    assign is_wr  = i_word.valid && (i_word.req.req_type == fbc_pkg::REQ_WRITE);
    assign wr_col = i_word.req.elem_index[3:2];
    assign wr_row = i_word.req.elem_index[1:0];
    assign wr_val = fbc_pkg::to_elem(i_word.req.elem_value);

    assign ctr[0]  = i_word.req.center_x;
    assign ctr[1]  = i_word.req.center_y;
    assign ctr[2]  = i_word.req.center_z;
    assign half[0] = i_word.req.half_x;
    assign half[1] = i_word.req.half_y;
    assign half[2] = i_word.req.half_z;

    // a*c + |a|*h folds into a*(c + h) or a*(c - h) by the sign of a
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_coef[k][fbc_pkg::CW-1]) begin
                n_t[k] = fbc_pkg::TW'(ctr[k]) - fbc_pkg::TW'($signed({1'b0, half[k]}));
            end else begin
                n_t[k] = fbc_pkg::TW'(ctr[k]) + fbc_pkg::TW'($signed({1'b0, half[k]}));
            end
            n_p[k] = r_coef[k] * n_t[k];
        end
    end

    // plane state update on element writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_r4[k]   <= '0;
                r_rr[k]   <= '0;
                r_coef[k] <= '0;
            end
        end else if (is_wr) begin
            if (wr_row == fbc_pkg::ROW_W) begin
                r_r4[wr_col] <= wr_val;
                if (i_neg) begin
                    r_coef[wr_col] <= fbc_pkg::CW'(wr_val) - fbc_pkg::CW'(r_rr[wr_col]);
                end else begin
                    r_coef[wr_col] <= fbc_pkg::CW'(wr_val) + fbc_pkg::CW'(r_rr[wr_col]);
                end
            end else if (wr_row == i_row) begin
                r_rr[wr_col] <= wr_val;
                if (i_neg) begin
                    r_coef[wr_col] <= fbc_pkg::CW'(r_r4[wr_col]) - fbc_pkg::CW'(wr_val);
                end else begin
                    r_coef[wr_col] <= fbc_pkg::CW'(r_r4[wr_col]) + fbc_pkg::CW'(wr_val);
                end
            end
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_word.valid <= 1'b0;
        end else begin
            r_s1_word <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_p[k] <= n_p[k];
        end
        r_d <= r_coef[3];
    end

    // stage 2: distance plus radius, drop visibility on a negative sum
    assign sum = fbc_pkg::SW'(r_p[0]) + fbc_pkg::SW'(r_p[1]) + fbc_pkg::SW'(r_p[2])
               + (fbc_pkg::SW'(r_d) <<< fbc_pkg::FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= r_s1_word.valid;
            r_out.req   <= r_s1_word.req;
            r_out.vis   <= r_s1_word.vis & ~sum[fbc_pkg::SW-1];
        end
    end

    assign o_word = r_out;

endmodule

>>> rtl/core/fbc_out_fifo.sv
// Result queue at the end of the cell chain.
`timescale 1ns / 1ps

module fbc_out_fifo (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  logic i_wr_data,
    input  logic i_rd,
    output logic o_valid,
    output logic o_data
);

    logic                       r_mem [fbc_pkg::FIFO_DEPTH];
    logic [fbc_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [fbc_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [fbc_pkg::FIFO_AW:0]   r_count;
    logic                       pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/frustum_box_cull_core.sv
// Frustum box cull core: request capture, chain of six plane cells, result queue.
//
// Request channel i_req carries one word per handshake: req_type 0 writes one
// element of the column-major view-projection matrix (no response), req_type 1
// tests one box and yields one response word on o_rsp with the visible bit.
// Every word passes through a capture register and then six plane cells
// (left, right, bottom, top, near, far), two register stages per cell: one for
// the three coefficient products, one for the wide sum and sign test. Each cell
// holds its own plane coefficients, so a write updates the planes in order with
// the tests around it.
// Throughput: one word per cycle while i_req.ready is high, writes and tests mixed freely.
// A 16-entry result queue decouples the receiver; i_req.ready drops only when
// tests in flight plus queued responses reach 16, so a stalled receiver stops
// intake after that many tests while writes already inside still complete.
// Reset clears the matrix (every box then reads visible), the queue and the
// pipeline valid bits.
`timescale 1ns / 1ps

module frustum_box_cull_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fbc_req_if.sink      i_req,
    fbc_rsp_if.source    o_rsp
);

    fbc_pkg::t_word            r_in;
    fbc_pkg::t_word            w_chain [fbc_pkg::NUM_PLANES+1];
    logic [fbc_pkg::FIFO_AW:0] r_used;
    logic                      accept;
    logic                      test_in;
    logic                      rsp_done;
    logic                      q_wr;
    logic                      q_valid;
    logic                      q_data;

    assign i_req.ready = (r_used < (fbc_pkg::FIFO_AW+1)'(fbc_pkg::FIFO_DEPTH));
    assign accept      = i_req.valid && i_req.ready;
    assign test_in     = accept && (i_req.payload.req_type == fbc_pkg::REQ_TEST);
    assign rsp_done    = o_rsp.valid && o_rsp.ready;

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in.valid <= accept;
            r_in.req   <= i_req.payload;
            r_in.vis   <= 1'b1;
        end
    end

    // count tests in flight plus responses waiting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            case ({test_in, rsp_done})
                2'b10:   r_used <= r_used + 1'b1;
                2'b01:   r_used <= r_used - 1'b1;
                default: r_used <= r_used;
            endcase
        end
    end

    assign w_chain[0] = r_in;

    for (genvar g = 0; g < fbc_pkg::NUM_PLANES; g++) begin : g_cell
        fbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_row   (2'(g / 2)),
            .i_neg   (1'(g % 2)),
            .i_word  (w_chain[g]),
            .o_word  (w_chain[g+1])
        );
    end

    assign q_wr = w_chain[fbc_pkg::NUM_PLANES].valid
               && (w_chain[fbc_pkg::NUM_PLANES].req.req_type == fbc_pkg::REQ_TEST);

    fbc_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (w_chain[fbc_pkg::NUM_PLANES].vis),
        .i_rd      (o_rsp.ready),
        .o_valid   (q_valid),
        .o_data    (q_data)
    );

    assign o_rsp.valid           = q_valid;
    assign o_rsp.payload.visible = q_data;

endmodule

>>> tb/frustum_box_cull_checker.sv
// Checker for the frustum box cull core: tracks the matrix, predicts visibility, checks responses.
`timescale 1ns / 1ps

module frustum_box_cull_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fbc_req_if   i_req,
    fbc_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    fbc_pkg::t_elem vp_matrix [16];
    logic  expected_visible [$];
    logic  want_visible;
    int    mismatches = 0;

    // Exact plane test: sum distance and radius in 128 bits, cull on a negative sum.
    function automatic logic predict_visible(fbc_pkg::t_req r);
        logic signed [127:0] center [3];
        logic signed [127:0] half [3];
        logic signed [127:0] coef;
        logic signed [127:0] margin;
        logic vis;
        vis = 1'b1;
        center[0] = r.center_x;
        center[1] = r.center_y;
        center[2] = r.center_z;
        half[0] = {97'd0, r.half_x};
        half[1] = {97'd0, r.half_y};
        half[2] = {97'd0, r.half_z};
        for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
            margin = '0;
            for (int k = 0; k < 4; k++) begin
                // even planes add the row to the fourth row, odd planes subtract it
                coef = (p % 2 == 0) ? vp_matrix[4*k+3] + vp_matrix[4*k+p/2]
                                    : vp_matrix[4*k+3] - vp_matrix[4*k+p/2];
                if (k < 3)
                    margin += coef * center[k] + ((coef < 0) ? -coef : coef) * half[k];
                else
                    margin += coef <<< fbc_pkg::FRAC_BITS;
            end
            if (margin < 0)
                vis = 1'b0;
        end
        return vis;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (vp_matrix[i])
                vp_matrix[i] = '0;
            expected_visible.delete();
        end else begin
            // check the response before taking in a new word at the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_visible.size() == 0) begin
                    $error("visible: response with no test outstanding, expected none, actual %0b",
                           i_rsp.payload.visible);
                    mismatches++;
                end else begin
                    want_visible = expected_visible.pop_front();
                    if (i_rsp.payload.visible !== want_visible) begin
                        $error("visible: expected %0b, actual %0b",
                               want_visible, i_rsp.payload.visible);
                        mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.payload.req_type == fbc_pkg::REQ_TEST)
                    expected_visible.push_back(predict_visible(i_req.payload));
                else
                    vp_matrix[i_req.payload.elem_index] =
                        fbc_pkg::to_elem(i_req.payload.elem_value);
            end
        end
        o_pending <= expected_visible.size();
    end

    assign o_fail_count = mismatches;

endmodule

>>> tb/frustum_box_cull_core_tb.sv
// Testbench top for the frustum box cull core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module frustum_box_cull_core_tb;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic [30:0]        H_MAX = 31'h7fff_ffff;

    logic clk;
    logic rst_n;
    bit   quiet = 1'b0;
    bit   hold_off_req = 1'b0;
    int   fail_count;
    int   pending;

    fbc_req_if req_if ();
    fbc_rsp_if rsp_if ();

    frustum_box_cull_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    frustum_box_cull_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly values within +/-4.0, some full range, some at the extremes.
    function automatic logic signed [31:0] rand_fixed();
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return int'($urandom_range(0, 32'h80000)) - 32'sh40000;
        endcase
    endfunction

    function automatic logic [30:0] rand_half();
        case ($urandom_range(0, 7))
            0, 1: return 31'($urandom);
            2: return ($urandom_range(0, 1) != 0) ? H_MAX : 31'd0;
            default: return 31'($urandom_range(0, 32'h30000));
        endcase
    endfunction

    // Every field is filled; the block ignores those of the other request type.
    function automatic fbc_pkg::t_req rand_word(logic kind);
        fbc_pkg::t_req w;
        w.req_type   = kind;
        w.elem_index = 4'($urandom);
        w.elem_value = rand_fixed();
        w.center_x   = rand_fixed();
        w.center_y   = rand_fixed();
        w.center_z   = rand_fixed();
        w.half_x     = rand_half();
        w.half_y     = rand_half();
        w.half_z     = rand_half();
        return w;
    endfunction

    function automatic fbc_pkg::t_req make_write(logic [3:0] idx, logic signed [31:0] val);
        fbc_pkg::t_req w;
        w = rand_word(fbc_pkg::REQ_WRITE);
        w.elem_index = idx;
        w.elem_value = val;
        return w;
    endfunction

    function automatic fbc_pkg::t_req make_test(logic signed [31:0] cx, logic signed [31:0] cy,
                                                logic signed [31:0] cz, logic [30:0] hx,
                                                logic [30:0] hy, logic [30:0] hz);
        fbc_pkg::t_req w;
        w = rand_word(fbc_pkg::REQ_TEST);
        w.center_x = cx;
        w.center_y = cy;
        w.center_z = cz;
        w.half_x   = hx;
        w.half_y   = hy;
        w.half_z   = hz;
        return w;
    endfunction

    // Offer one word, hold it until taken, then maybe drop valid for a short burst.
    task automatic send_word(input fbc_pkg::t_req w);
        req_if.payload <= w;
        req_if.valid   <= 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Receiver: short random stalls, plus one long hold-off on request.
    initial begin
        rsp_if.ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (300) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic signed [31:0] val;
        int sent;
        int guard;
        bit hold_done;
        sent = 0;
        hold_done = 1'b0;
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset matrix: every plane degenerate, all boxes visible
        send_word(make_test(Q_MAX, Q_MAX, Q_MAX, H_MAX, H_MAX, H_MAX));
        send_word(make_test(Q_MIN, Q_MIN, Q_MIN, 31'd0, 31'd0, 31'd0));

        // identity matrix: clip cube [-1,1]^3
        send_word(make_write(4'd0, Q_ONE));
        send_word(make_write(4'd5, Q_ONE));
        send_word(make_write(4'd10, Q_ONE));
        send_word(make_write(4'd15, Q_ONE));
        send_word(make_test('0, '0, '0, 31'd0, 31'd0, 31'd0));
        // box touching the left plane exactly stays visible, one step short is culled
        send_word(make_test(-2 * Q_ONE, '0, '0, 31'h10000, 31'd0, 31'd0));
        send_word(make_test(-2 * Q_ONE, '0, '0, 31'h0ffff, 31'd0, 31'd0));
        send_word(make_test('0, '0, 3 * Q_ONE, 31'd0, 31'd0, 31'd0));
        send_word(make_test('0, 2 * Q_ONE, '0, 31'd0, 31'h10000, 31'd0));

        // extreme elements, including a coefficient that needs the extra bit
        send_word(make_write(4'd3, Q_MIN));
        send_word(make_write(4'd12, Q_MAX));
        send_word(make_write(4'd0, Q_MAX));
        send_word(make_write(4'd7, Q_MIN));
        send_word(make_write(4'd4, Q_MIN));
        send_word(make_test(Q_MAX, Q_MAX, Q_MAX, H_MAX, H_MAX, H_MAX));
        send_word(make_test(Q_MIN, Q_MIN, Q_MIN, H_MAX, H_MAX, H_MAX));
        send_word(make_write(4'd15, Q_MIN));
        send_word(make_test(Q_MIN, Q_MAX, Q_MIN, 31'd0, H_MAX, 31'd0));

        while (sent < 1575) begin
            if (sent >= 1375)
                quiet = 1'b1;
            if (sent >= 100 && !hold_done) begin
                hold_off_req = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 49) == 0) begin
                // reload a near-identity matrix so the planes stay meaningful
                for (int i = 0; i < 16; i++) begin
                    val = (i % 4 == i / 4) ? Q_ONE : 32'sd0;
                    val += int'($urandom_range(0, 32'h8000)) - 32'sh4000;
                    send_word(make_write(i[3:0], val));
                end
                sent += 16;
            end else begin
                if ($urandom_range(0, 4) == 0)
                    send_word(rand_word(fbc_pkg::REQ_WRITE));
                else
                    send_word(rand_word(fbc_pkg::REQ_TEST));
                sent++;
            end
        end
        req_if.valid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);

        if (pending != 0)
            $error("visible: expected %0d more responses, actual none", pending);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
rtl/core/fbc_pkg.sv
rtl/core/fbc_if.sv
rtl/core/fbc_cell.sv
rtl/core/fbc_out_fifo.sv
rtl/core/frustum_box_cull_core.sv
tb/frustum_box_cull_checker.sv
tb/frustum_box_cull_core_tb.sv
